// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion shorthands used by the rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lmr_pkg
// shared types and constants of the 5x5 local mean removal core
// ----------------------------------------------------------------------------
package lmr_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 5;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 12;
  localparam int WCFG_W = 8;
  localparam int HCFG_W = 13;
  localparam int CFG_W  = 13;
  localparam int RES_W  = 9;

  localparam int LINES  = 4;
  localparam int TAPS   = 5;
  localparam int CSUM_W = 11;
  localparam int WSUM_W = 13;

  // floor(x / 25) for x < 6400 as (x * 5243) >> 17
  localparam int          DIV_SHIFT = 17;
  localparam logic [12:0] DIV_RECIP = 13'd5243;
  localparam int          PROD_W    = 26;

  typedef enum logic {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] px;
    logic [CSUM_W-1:0]          sum;
  } column_t;

  typedef struct packed {
    logic                     en;
    logic [COL_W-1:0]         addr;
    logic [$clog2(LINES)-1:0] sel;
    pix_t                     data;
  } ls_access_t;

endpackage

// ===== rtl/lmr_if.sv =====
// ----------------------------------------------------------------------------
// lmr channel interfaces
// pixel input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lmr_pix_if
  import lmr_pkg::*;
;
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface lmr_res_if
  import lmr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] centered_value;
  logic [ROW_W-1:0]        center_row;
  logic [COL_W-1:0]        center_col;
  logic                    frame_last;

  modport source (output valid, centered_value, center_row, center_col, frame_last,
                  input ready);
  modport sink   (input valid, centered_value, center_row, center_col, frame_last,
                  output ready);
endinterface

// ===== rtl/lmr_line_store.sv =====
// ----------------------------------------------------------------------------
// lmr_line_store
// four line memories, all read at the current column, one written per pixel
// ----------------------------------------------------------------------------
module lmr_line_store
  import lmr_pkg::*;
(
  input  logic             clk,
  input  ls_access_t       acc,
  output pix_t [LINES-1:0] rd_data
);

  for (genvar b = 0; b < LINES; b++) begin : g_bank
    pix_t mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (acc.en) begin
        rd_data[b] <= mem[acc.addr];
        if (acc.sel == ($clog2(LINES))'(b)) begin
          mem[acc.addr] <= acc.data;
        end
      end
    end
  end

endmodule

// ===== rtl/lmr_cell.sv =====
// ----------------------------------------------------------------------------
// lmr_cell
// one window column with its sum, shifted toward the older neighbor
// ----------------------------------------------------------------------------
module lmr_cell
  import lmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  column_t col_in,
  output column_t col_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

// ===== rtl/local_mean_removal_5x5_core.sv =====
// ----------------------------------------------------------------------------
// local_mean_removal_5x5_core
// raster-order 5x5 box mean subtraction over 8-bit grayscale pixels
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the result output is not stalled. Each pixel
// reads its column from four line memories and shifts it into a chain of five
// column cells; for every interior center the 25-pixel sum, the division by 25
// (a reciprocal multiply) and the subtraction run through a five-stage
// pipeline: stage 1, column cells, window sum, mean and output register.
// Border pixels give no transaction. A stalled result only holds the stages
// behind it that carry results, so pixels keep flowing while bubbles remain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_mean_removal_5x5_core
  import lmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lmr_pix_if.sink           pixels,
  lmr_res_if.source         results,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // configuration
  logic [WCFG_W-1:0] active_width;
  logic [HCFG_W-1:0] active_height;
  logic [WCFG_W-1:0] eff_w;
  logic [HCFG_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= WCFG_W'(MAX_WIDTH);
      active_height <= HCFG_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[WCFG_W-1:0];
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data[HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = active_width;
    if (active_width < WCFG_W'(MIN_SIZE)) eff_w = WCFG_W'(MIN_SIZE);
    if (active_width > WCFG_W'(MAX_WIDTH)) eff_w = WCFG_W'(MAX_WIDTH);
    eff_h = active_height;
    if (active_height < HCFG_W'(MIN_SIZE)) eff_h = HCFG_W'(MIN_SIZE);
    if (active_height > HCFG_W'(MAX_HEIGHT)) eff_h = HCFG_W'(MAX_HEIGHT);
  end

  // stage enables
  logic en1, en2, en3, en4, en_out;
  logic v1, v2, v3, v4;
  logic acc;

  assign en_out       = !results.valid || results.ready;
  assign en4          = !v4 || en_out;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign pixels.ready = en1;
  assign acc          = pixels.valid && en1;

  // position counters
  logic [COL_W-1:0] col_count, col_count_next, cur_col;
  logic [ROW_W-1:0] row_count, row_count_next, cur_row;
  logic [WCFG_W-1:0] col_inc;
  logic [HCFG_W-1:0] row_inc;
  logic prod, last;

  always_comb begin
    cur_col = col_count;
    cur_row = row_count;
    if (pixels.frame_start || {1'b0, col_count} >= eff_w) cur_col = '0;
    if (pixels.frame_start || {1'b0, row_count} >= eff_h) cur_row = '0;
    col_inc        = {1'b0, cur_col} + WCFG_W'(1);
    row_inc        = {1'b0, cur_row} + HCFG_W'(1);
    col_count_next = col_inc[COL_W-1:0];
    row_count_next = cur_row;
    if (col_inc >= eff_w) begin
      col_count_next = '0;
      row_count_next = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
    end
    prod = (cur_row >= ROW_W'(4)) && (cur_col >= COL_W'(4));
    last = ({1'b0, cur_row} == eff_h - HCFG_W'(1)) && ({1'b0, cur_col} == eff_w - WCFG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line memories
  ls_access_t       ls_acc;
  pix_t [LINES-1:0] ls_rd;

  assign ls_acc.en   = acc;
  assign ls_acc.addr = cur_col;
  assign ls_acc.sel  = cur_row[$clog2(LINES)-1:0];
  assign ls_acc.data = pixels.pixel;

  lmr_line_store u_line_store (
    .clk     (clk),
    .acc     (ls_acc),
    .rd_data (ls_rd)
  );

  // stage 1: pixel and position beside the memory read
  pix_t                     px1;
  logic [$clog2(LINES)-1:0] sel1;
  logic                     prod1, last1, last2, last3, last4;
  logic [ROW_W-1:0]         crow1, crow2, crow3, crow4;
  logic [COL_W-1:0]         ccol1, ccol2, ccol3, ccol4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1   <= pixels.pixel;
      sel1  <= cur_row[$clog2(LINES)-1:0];
      prod1 <= prod;
      last1 <= last;
      crow1 <= cur_row - ROW_W'(2);
      ccol1 <= cur_col - COL_W'(2);
    end
  end

  // new column, oldest line first
  column_t new_col;

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      new_col.px[i] = ls_rd[2'(sel1 + 2'(i))];
    end
    new_col.px[TAPS-1] = px1;
    new_col.sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      new_col.sum = new_col.sum + CSUM_W'(new_col.px[i]);
    end
  end

  // chain of column cells, cell TAPS-1 newest
  column_t [TAPS-1:0] win;
  logic               shift;

  assign shift = v1 && en2;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    column_t cin;
    if (k == TAPS - 1) begin : g_head
      assign cin = new_col;
    end else begin : g_body
      assign cin = win[k+1];
    end
    lmr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .col_in  (cin),
      .col_out (win[k])
    );
  end

  // stage 2: window complete for a result-bearing pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1 && prod1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      crow2 <= crow1;
      ccol2 <= ccol1;
      last2 <= last1;
    end
  end

  // stage 3: window sum
  logic [WSUM_W-1:0] wsum;
  logic [WSUM_W-1:0] sum3;
  pix_t              center3, center4;

  always_comb begin
    wsum = '0;
    for (int k = 0; k < TAPS; k++) begin
      wsum = wsum + WSUM_W'(win[k].sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sum3    <= wsum;
      center3 <= win[2].px[2];
      crow3   <= crow2;
      ccol3   <= ccol2;
      last3   <= last2;
    end
  end

  // stage 4: floor of the mean by reciprocal multiply
  logic [PROD_W-1:0] prod_full;
  logic [RES_W-1:0]  q4;

  assign prod_full = PROD_W'(sum3) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      q4      <= prod_full[DIV_SHIFT +: RES_W];
      center4 <= center3;
      crow4   <= crow3;
      ccol4   <= ccol3;
      last4   <= last3;
    end
  end

  // output register
  logic [RES_W-1:0] diff;

  assign diff = {1'b0, center4} - q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en_out) begin
      results.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      results.centered_value <= $signed(diff);
      results.center_row     <= crow4;
      results.center_col     <= ccol4;
      results.frame_last     <= last4;
    end
  end

  // checks
  `ASSERT_IMPLIES(a_ready_when_out_empty, clk, rst, !results.valid, pixels.ready)
  `ASSERT_NEXT(a_frame_start_restart, clk, rst, acc && pixels.frame_start,
               col_count == COL_W'(1) && row_count == '0)
  `ASSERT_IMPLIES(a_mean_in_range, clk, rst, v4, q4[RES_W-1] == 1'b0)

endmodule
